// File: rtl/core/wbsc_pkg.sv
// Shared constants, result codes and controller/datapath handshake types for the sector chunker.
`timescale 1ns / 1ps
package wbsc_pkg;

    localparam int unsigned SECTORS_PER_PAGE = 8;
    localparam int unsigned MAX_PAGES        = 64;
    localparam int unsigned ADDRESS_SPACE    = 65536;
    localparam int unsigned MAX_COUNT        = 256;

    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned SLOT_W  = 6;
    localparam int unsigned POS_W   = 3;
    localparam int unsigned CHUNK_W = 4;
    localparam int unsigned RING_W  = 7;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned VER_W   = 8;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Register index of ring_pages
    localparam logic REG_RING_PAGES = 1'b0;

    typedef struct packed {
        logic load;    // take the input item
        logic sector;  // process one sector of the current chunk
        logic emit;    // load the chunk result and advance the ring
        logic stat;    // load a status-only result
    } t_cmd;

    typedef struct packed {
        logic clear_done;  // version store clearing pass finished
        logic in_bad;      // the offered item is empty or out of range
        logic chunk_end;   // the sector processed this cycle ends the chunk
        logic req_done;    // no sectors left in the request
        logic out_free;    // output register can take a result this cycle
    } t_sts;

endpackage

// File: rtl/core/wbsc_ctrl.sv
// Controller state machine sequencing sectors, chunk results and status results.
`timescale 1ns / 1ps
module wbsc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  wbsc_pkg::t_sts i_sts,
    output wbsc_pkg::t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SECT  = 3'd2;
    localparam logic [2:0] S_EMIT  = 3'd3;
    localparam logic [2:0] S_STAT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = i_sts.clear_done;
                if (i_in_valid && i_sts.clear_done) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_bad ? S_STAT : S_SECT;
                end
            end
            S_SECT: begin
                o_cmd.sector = 1'b1;
                if (i_sts.chunk_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register frees up
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.req_done ? S_IDLE : S_SECT;
                end
            end
            S_STAT: begin
                if (i_sts.out_free) begin
                    o_cmd.stat = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/wbsc_dpath.sv
// Datapath: ring pointer, chunk counters, sector table, version store and result register.
`timescale 1ns / 1ps
module wbsc_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  wbsc_pkg::t_cmd                    i_cmd,
    output wbsc_pkg::t_sts                    o_sts,
    input  logic [wbsc_pkg::ADDR_W-1:0]       i_start_address,
    input  logic [wbsc_pkg::COUNT_W-1:0]      i_sector_count,
    input  logic                              i_cfg_we,
    input  logic [wbsc_pkg::RING_W-1:0]       i_cfg_data,
    output logic [wbsc_pkg::RING_W-1:0]       o_ring_pages,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wbsc_pkg::SLOT_W-1:0]       o_slot,
    output logic [wbsc_pkg::POS_W-1:0]        o_first_sector,
    output logic [wbsc_pkg::CHUNK_W-1:0]      o_chunk_sectors,
    output logic [wbsc_pkg::ADDR_W-1:0]       o_chunk_address,
    output logic [wbsc_pkg::STAT_W-1:0]       o_status,
    output logic                              o_last
);

    localparam int unsigned TBL_W = wbsc_pkg::SLOT_W + wbsc_pkg::POS_W;

    // Ring and request state
    logic [wbsc_pkg::RING_W-1:0]  r_ring_pages;
    logic [wbsc_pkg::SLOT_W-1:0]  r_ptr;
    logic [wbsc_pkg::MAX_PAGES-1:0] r_tagged;
    logic [wbsc_pkg::ADDR_W-1:0]  r_addr;
    logic [wbsc_pkg::ADDR_W-1:0]  r_chunk_addr;
    logic [wbsc_pkg::POS_W-1:0]   r_first;
    logic [wbsc_pkg::POS_W-1:0]   r_pos;
    logic [wbsc_pkg::COUNT_W-1:0] r_left;
    logic [wbsc_pkg::CHUNK_W-1:0] r_cnt;
    logic [wbsc_pkg::STAT_W-1:0]  r_code;

    // Version store and its clearing pass
    logic [wbsc_pkg::VER_W-1:0]   r_version_mem [0:wbsc_pkg::ADDRESS_SPACE-1];
    logic [wbsc_pkg::VER_W-1:0]   r_ver_rdata;
    logic [wbsc_pkg::ADDR_W-1:0]  r_ver_waddr;
    logic                         r_rmw_pending;
    logic [wbsc_pkg::ADDR_W-1:0]  r_clr_addr;
    logic                         r_clr_done;

    // Sector address table, written only
    logic [wbsc_pkg::ADDR_W-1:0]  r_sector_table [0:(1 << TBL_W)-1];

    // Result register
    logic                         r_out_valid;
    logic [wbsc_pkg::SLOT_W-1:0]  r_out_slot;
    logic [wbsc_pkg::POS_W-1:0]   r_out_first;
    logic [wbsc_pkg::CHUNK_W-1:0] r_out_cnt;
    logic [wbsc_pkg::ADDR_W-1:0]  r_out_addr;
    logic [wbsc_pkg::STAT_W-1:0]  r_out_status;
    logic                         r_out_last;

    logic [wbsc_pkg::ADDR_W:0]    in_end;
    logic [wbsc_pkg::STAT_W-1:0]  in_code;
    logic [wbsc_pkg::SLOT_W-1:0]  ptr_next;
    logic [wbsc_pkg::RING_W-1:0]  cfg_pages;
    logic                         out_free;
    logic                         ver_we;
    logic [wbsc_pkg::ADDR_W-1:0]  ver_waddr;
    logic [wbsc_pkg::VER_W-1:0]   ver_wdata;

    // Classify the offered item
    always_comb begin
        in_end = {1'b0, i_start_address} +
                 {{(wbsc_pkg::ADDR_W + 1 - wbsc_pkg::COUNT_W){1'b0}}, i_sector_count};
        priority if (i_sector_count == '0) begin
            in_code = wbsc_pkg::ST_EMPTY;
        end else if (i_sector_count > wbsc_pkg::COUNT_W'(wbsc_pkg::MAX_COUNT) ||
                     in_end > (wbsc_pkg::ADDR_W + 1)'(wbsc_pkg::ADDRESS_SPACE)) begin
            in_code = wbsc_pkg::ST_RANGE;
        end else begin
            in_code = wbsc_pkg::ST_DONE;
        end
    end

    always_comb begin
        if ({1'b0, r_ptr} + 7'd1 == r_ring_pages) begin
            ptr_next = '0;
        end else begin
            ptr_next = r_ptr + 6'd1;
        end
    end

    // Saturate the ring size into 1..MAX_PAGES
    always_comb begin
        priority if (i_cfg_data == '0) begin
            cfg_pages = 7'd1;
        end else if (i_cfg_data > wbsc_pkg::RING_W'(wbsc_pkg::MAX_PAGES)) begin
            cfg_pages = wbsc_pkg::RING_W'(wbsc_pkg::MAX_PAGES);
        end else begin
            cfg_pages = i_cfg_data;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_sts.clear_done = r_clr_done;
        o_sts.in_bad     = (in_code != wbsc_pkg::ST_DONE);
        o_sts.chunk_end  = (r_pos == '1) || (r_left == 9'd1);
        o_sts.req_done   = (r_left == '0);
        o_sts.out_free   = out_free;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_pages  <= wbsc_pkg::RING_W'(wbsc_pkg::MAX_PAGES);
            r_ptr         <= '0;
            r_tagged      <= '0;
            r_left        <= '0;
            r_cnt         <= '0;
            r_rmw_pending <= 1'b0;
            r_clr_addr    <= '0;
            r_clr_done    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_rmw_pending <= i_cmd.sector;
            if (!r_clr_done) begin
                r_clr_addr <= r_clr_addr + 16'd1;
                if (r_clr_addr == '1) begin
                    r_clr_done <= 1'b1;
                end
            end
            if (i_cfg_we) begin
                r_ring_pages <= cfg_pages;
                r_ptr        <= '0;
            end
            if (i_cmd.load) begin
                r_left <= i_sector_count;
                r_cnt  <= '0;
            end
            if (i_cmd.sector) begin
                r_left <= r_left - 9'd1;
                r_cnt  <= r_cnt + 4'd1;
            end
            if (i_cmd.emit) begin
                r_tagged[r_ptr] <= 1'b1;
                r_ptr           <= ptr_next;
                r_cnt           <= '0;
            end
            if (i_cmd.emit || i_cmd.stat) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Address counters and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_addr       <= i_start_address;
            r_chunk_addr <= i_start_address;
            r_first      <= i_start_address[wbsc_pkg::POS_W-1:0];
            r_pos        <= i_start_address[wbsc_pkg::POS_W-1:0];
            r_code       <= in_code;
        end
        if (i_cmd.sector) begin
            r_addr      <= r_addr + 16'd1;
            r_pos       <= r_pos + 3'd1;
            r_ver_waddr <= r_addr;
        end
        if (i_cmd.emit) begin
            // next chunk opens at the page start
            r_first      <= r_pos;
            r_chunk_addr <= r_addr;
            r_out_slot   <= r_ptr;
            r_out_first  <= r_first;
            r_out_cnt    <= r_cnt;
            r_out_addr   <= r_chunk_addr;
            r_out_status <= wbsc_pkg::ST_DONE;
            r_out_last   <= (r_left == '0);
        end
        if (i_cmd.stat) begin
            r_out_slot   <= '0;
            r_out_first  <= '0;
            r_out_cnt    <= '0;
            r_out_addr   <= '0;
            r_out_status <= r_code;
            r_out_last   <= 1'b1;
        end
    end

    // Version store: clear after reset, then one read-modify-write per sector
    always_comb begin
        if (!r_clr_done) begin
            ver_we    = 1'b1;
            ver_waddr = r_clr_addr;
            ver_wdata = '0;
        end else begin
            ver_we    = r_rmw_pending;
            ver_waddr = r_ver_waddr;
            ver_wdata = r_ver_rdata + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ver_we) begin
            r_version_mem[ver_waddr] <= ver_wdata;
        end
        r_ver_rdata <= r_version_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sector) begin
            r_sector_table[{r_ptr, r_pos}] <= r_addr;
        end
    end

    assign o_ring_pages    = r_ring_pages;
    assign o_out_valid     = r_out_valid;
    assign o_slot          = r_out_slot;
    assign o_first_sector  = r_out_first;
    assign o_chunk_sectors = r_out_cnt;
    assign o_chunk_address = r_out_addr;
    assign o_status        = r_out_status;
    assign o_last          = r_out_last;

`ifndef SYNTHESIS
    a_ptr_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_ptr} < r_ring_pages)
        else $error("ring pointer beyond ring size");

    a_ring_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ring_pages != '0 && r_ring_pages <= wbsc_pkg::RING_W'(wbsc_pkg::MAX_PAGES))
        else $error("ring size out of range");

    a_no_sector_past_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.sector |-> r_left != '0 && r_clr_done)
        else $error("sector processed with none left or before clearing");

    a_chunk_fits_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_cnt != '0 &&
            ({1'b0, r_first} + r_cnt) <= wbsc_pkg::CHUNK_W'(wbsc_pkg::SECTORS_PER_PAGE))
        else $error("chunk does not fit its page");

    a_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.stat) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");
`endif

endmodule

// File: rtl/core/write_buffer_sector_chunker.sv
// Top level of the write buffer sector chunker: handshake, register port and submodules.
`timescale 1ns / 1ps
// Splits a host write (start address, sector count) into page chunks on a ring of
// write buffer pages and returns one result item per chunk, last set on the final one;
// an empty or out-of-range request returns a single status item and changes nothing.
// After reset the block clears its 64K-entry version store, one entry a cycle, and
// takes no item until that pass ends; register writes are taken throughout. Then an
// item is accepted when idle, its sectors run one per cycle, and each chunk result
// loads in an emit state that waits while the result register is full; each sector's
// version counter is read and written back in turn. The result register lets the next
// chunk proceed while a result waits. Writing ring_pages (address 0) clamps it to 1..64
// and zeroes the ring pointer; the user must write it only while idle; no check is made.
module write_buffer_sector_chunker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [wbsc_pkg::ADDR_W-1:0]       i_start_address,
    input  logic [wbsc_pkg::COUNT_W-1:0]      i_sector_count,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wbsc_pkg::SLOT_W-1:0]       o_slot,
    output logic [wbsc_pkg::POS_W-1:0]        o_first_sector,
    output logic [wbsc_pkg::CHUNK_W-1:0]      o_chunk_sectors,
    output logic [wbsc_pkg::ADDR_W-1:0]       o_chunk_address,
    output logic [wbsc_pkg::STAT_W-1:0]       o_status,
    output logic                              o_last,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [2:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    wbsc_pkg::t_cmd              cmd;
    wbsc_pkg::t_sts              sts;
    logic                        cfg_we;
    logic [wbsc_pkg::RING_W-1:0] ring_pages;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == wbsc_pkg::REG_RING_PAGES);

    always_comb begin
        if (paddr[2] == wbsc_pkg::REG_RING_PAGES) begin
            prdata = {{(32 - wbsc_pkg::RING_W){1'b0}}, ring_pages};
        end else begin
            prdata = '0;
        end
    end

    wbsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wbsc_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_start_address (i_start_address),
        .i_sector_count  (i_sector_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (pwdata[wbsc_pkg::RING_W-1:0]),
        .o_ring_pages    (ring_pages),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_slot          (o_slot),
        .o_first_sector  (o_first_sector),
        .o_chunk_sectors (o_chunk_sectors),
        .o_chunk_address (o_chunk_address),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule
